// ===== design/rbfs_pkg.sv =====
package rbfs_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_NUM_QUEUES  = 4;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int EDGE_W    = 16;
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;
  localparam int CMD_W     = 2;
  localparam int SEL_W     = 2;
  localparam int STAT_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_BOTTOM = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd4;

  typedef logic [EDGE_W-1:0] edge_t;

  localparam edge_t EDGE_RESET [NUM_REGS] = '{16'd0, 16'd25, 16'd50, 16'd75, 16'd100};

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_DRAIN  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_RANGE   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_DRAINED = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

// ===== design/range_bucketed_fifo_set.sv =====
// Four (NUM_QUEUES) bounded FIFOs of QUEUE_DEPTH entries share one synchronous entry store.
// An enqueue or count item is accepted while idle and its single result appears on the out_
// ports in the cycle after acceptance; these items can be issued every cycle while busy is low.
// A drain of a queue holding n entries keeps busy high while its entries are read out and emits
// one drained entry per cycle, oldest first; the first follows acceptance through the ST_DRAIN
// state and the output and read-data registers, and out_last marks the final one. Draining an
// empty queue gives one empty status. Results are strobed for exactly one cycle and must be
// taken when shown. Edge registers are to be written through cfg_ only while the block is idle;
// the block itself does not enforce this, and no clearing pass runs after reset.
module range_bucketed_fifo_set #(
  parameter int QUEUE_DEPTH = rbfs_pkg::DEF_QUEUE_DEPTH,
  parameter int NUM_QUEUES  = rbfs_pkg::DEF_NUM_QUEUES,
  parameter int VALUE_WIDTH = rbfs_pkg::DEF_VALUE_WIDTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rbfs_pkg::CMD_W-1:0]     in_cmd,
  input  logic [rbfs_pkg::SEL_W-1:0]     in_queue_sel,
  input  logic [VALUE_WIDTH-1:0]         in_value,
  output logic                           out_strobe,
  output logic [rbfs_pkg::STAT_W-1:0]    out_status,
  output logic [rbfs_pkg::SEL_W-1:0]     out_bucket,
  output logic [CW-1:0]                  out_entry_count,
  output logic [VALUE_WIDTH-1:0]         out_data_out,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [rbfs_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rbfs_pkg::EDGE_W-1:0]    cfg_data
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = (VALUE_WIDTH > rbfs_pkg::EDGE_W) ? VALUE_WIDTH : rbfs_pkg::EDGE_W;

  function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] q, input logic [SW-1:0] s);
    addr_of = AW'(int'(q) * QUEUE_DEPTH + int'(s));
  endfunction

  rbfs_pkg::edge_t edges_r [rbfs_pkg::NUM_REGS];

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;

  logic [SW-1:0] head_r   [NUM_QUEUES];
  logic [SW-1:0] head_nxt [NUM_QUEUES];
  logic [CW-1:0] fill_r   [NUM_QUEUES];
  logic [CW-1:0] fill_nxt [NUM_QUEUES];

  rbfs_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic [QW-1:0]    dq_r, dq_nxt;

  logic                        out_strobe_r, out_strobe_nxt;
  rbfs_pkg::status_t           out_status_r, out_status_nxt;
  logic [rbfs_pkg::SEL_W-1:0]  out_bucket_r, out_bucket_nxt;
  logic [CW-1:0]               out_count_r, out_count_nxt;
  logic                        out_last_r, out_last_nxt;

  logic          hit;
  logic [QW-1:0] hit_q;
  logic [QW-1:0] sel_q;
  logic          sel_ok;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot;
  logic [SW:0]   head_sum;
  logic [SW-1:0] head_after;

  // classifier, lowest matching queue wins
  always_comb begin
    logic [CMP_W-1:0] v;
    logic [CMP_W-1:0] lo;
    logic [CMP_W-1:0] hi;
    v     = CMP_W'(in_value);
    hit   = 1'b0;
    hit_q = '0;
    for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
      lo = CMP_W'(edges_r[q]);
      hi = (q == NUM_QUEUES - 1) ? CMP_W'(edges_r[rbfs_pkg::REG_TOP]) : CMP_W'(edges_r[q + 1]);
      if (v > lo && v <= hi) begin
        hit   = 1'b1;
        hit_q = QW'(q);
      end
    end
  end

  assign sel_q  = in_queue_sel[QW-1:0];
  assign sel_ok = {1'b0, in_queue_sel} < 3'(NUM_QUEUES);

  always_comb begin
    slot_sum = (SW+1)'(head_r[hit_q]) + (SW+1)'(fill_r[hit_q]);
    if (slot_sum >= (SW+1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (SW+1)'(QUEUE_DEPTH);
    end
    slot = slot_sum[SW-1:0];
    head_sum = (SW+1)'(head_r[sel_q]) + (SW+1)'(fill_r[sel_q]);
    if (head_sum >= (SW+1)'(QUEUE_DEPTH)) begin
      head_sum = head_sum - (SW+1)'(QUEUE_DEPTH);
    end
    head_after = head_sum[SW-1:0];
  end

  assign mem_waddr = addr_of(hit_q, slot);
  assign mem_raddr = addr_of(dq_r, ptr_r);
  assign busy      = (state_r == rbfs_pkg::ST_DRAIN);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    dq_nxt         = dq_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    mem_we         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      rbfs_pkg::ST_IDLE: begin
        if (start) begin
          case (rbfs_pkg::cmd_t'(in_cmd))
            rbfs_pkg::CMD_ENQ: begin
              out_strobe_nxt = 1'b1;
              out_last_nxt   = 1'b1;
              if (!hit) begin
                out_status_nxt = rbfs_pkg::STAT_RANGE;
                out_bucket_nxt = '0;
                out_count_nxt  = '0;
              end else if (fill_r[hit_q] >= CW'(QUEUE_DEPTH)) begin
                out_status_nxt = rbfs_pkg::STAT_FULL;
                out_bucket_nxt = rbfs_pkg::SEL_W'(hit_q);
                out_count_nxt  = CW'(QUEUE_DEPTH);
              end else begin
                mem_we          = 1'b1;
                fill_nxt[hit_q] = fill_r[hit_q] + 1'b1;
                out_status_nxt  = rbfs_pkg::STAT_OK;
                out_bucket_nxt  = rbfs_pkg::SEL_W'(hit_q);
                out_count_nxt   = fill_r[hit_q] + 1'b1;
              end
            end
            rbfs_pkg::CMD_COUNT: begin
              if (sel_ok) begin
                out_strobe_nxt = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = rbfs_pkg::STAT_OK;
                out_bucket_nxt = in_queue_sel;
                out_count_nxt  = fill_r[sel_q];
              end
            end
            rbfs_pkg::CMD_DRAIN: begin
              if (sel_ok) begin
                if (fill_r[sel_q] == '0) begin
                  out_strobe_nxt = 1'b1;
                  out_last_nxt   = 1'b1;
                  out_status_nxt = rbfs_pkg::STAT_EMPTY;
                  out_bucket_nxt = in_queue_sel;
                  out_count_nxt  = '0;
                end else begin
                  state_nxt       = rbfs_pkg::ST_DRAIN;
                  ptr_nxt         = head_r[sel_q];
                  left_nxt        = fill_r[sel_q];
                  dq_nxt          = sel_q;
                  head_nxt[sel_q] = head_after;
                  fill_nxt[sel_q] = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      rbfs_pkg::ST_DRAIN: begin
        out_strobe_nxt = 1'b1;
        out_status_nxt = rbfs_pkg::STAT_DRAINED;
        out_bucket_nxt = rbfs_pkg::SEL_W'(dq_r);
        out_count_nxt  = left_r - 1'b1;
        out_last_nxt   = (left_r == CW'(1));
        ptr_nxt        = (ptr_r == SW'(QUEUE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
        left_nxt       = left_r - 1'b1;
        if (left_r == CW'(1)) begin
          state_nxt = rbfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbfs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_value;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rbfs_pkg::NUM_REGS; i++) begin
        edges_r[i] <= rbfs_pkg::EDGE_RESET[i];
      end
    end else if (cfg_we && cfg_index < rbfs_pkg::REG_IDX_W'(rbfs_pkg::NUM_REGS)) begin
      edges_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rbfs_pkg::ST_IDLE;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    left_r       <= left_nxt;
    dq_r         <= dq_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_bucket      = out_bucket_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;
  assign out_data_out    = (out_status_r == rbfs_pkg::STAT_DRAINED) ? rd_data_r : '0;

`ifndef SYNTHESIS
  a_drain_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbfs_pkg::ST_DRAIN |=> out_strobe && out_status == rbfs_pkg::STAT_DRAINED)
    else $error("drain cycle without drained entry");

  a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbfs_pkg::ST_DRAIN && left_r > CW'(1) |=> state_r == rbfs_pkg::ST_DRAIN)
    else $error("drain ended early");

  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last && out_status == rbfs_pkg::STAT_DRAINED |-> out_entry_count == '0)
    else $error("last drained entry leaves entries");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rbfs_pkg::ST_DRAIN |-> !mem_we)
    else $error("store written during drain");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;

  localparam int QUEUE_DEPTH    = rbfs_pkg::DEF_QUEUE_DEPTH;
  localparam int NUM_QUEUES     = rbfs_pkg::DEF_NUM_QUEUES;
  localparam int VW             = rbfs_pkg::DEF_VALUE_WIDTH;
  localparam int CW             = $clog2(QUEUE_DEPTH + 1);
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    rbfs_pkg::cmd_t              cmd;
    logic [rbfs_pkg::SEL_W-1:0]  sel;
    logic [VW-1:0]               value;
  } fifo_op_t;

  typedef struct packed {
    rbfs_pkg::status_t           status;
    logic [rbfs_pkg::SEL_W-1:0]  bucket;
    logic [CW-1:0]               count;
    logic [VW-1:0]               data;
    logic                        last;
  } fifo_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [rbfs_pkg::CMD_W-1:0]     in_cmd = '0;
  logic [rbfs_pkg::SEL_W-1:0]     in_queue_sel = '0;
  logic [VW-1:0]                  in_value = '0;
  logic                           out_strobe;
  logic [rbfs_pkg::STAT_W-1:0]    out_status;
  logic [rbfs_pkg::SEL_W-1:0]     out_bucket;
  logic [CW-1:0]                  out_entry_count;
  logic [VW-1:0]                  out_data_out;
  logic                           out_last;
  logic                           cfg_we = 1'b0;
  logic [rbfs_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [rbfs_pkg::EDGE_W-1:0]    cfg_data = '0;

  fifo_op_t     pending_ops[$];
  fifo_result_t due_results[$];
  fifo_op_t     cur_op;
  fifo_result_t want;

  rbfs_pkg::edge_t edge_regs [rbfs_pkg::NUM_REGS];
  logic [VW-1:0]   mirror_store [NUM_QUEUES][QUEUE_DEPTH];
  logic [4:0]      mirror_head [NUM_QUEUES];
  logic [CW-1:0]   mirror_fill [NUM_QUEUES];

  logic item_taken = 1'b0;
  logic steady_feed = 1'b0;
  int   idle_left = 0;
  int   quiet_cycles = 0;
  int   fail_count = 0;

  range_bucketed_fifo_set u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_queue_sel   (in_queue_sel),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_bucket     (out_bucket),
    .out_entry_count(out_entry_count),
    .out_data_out   (out_data_out),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int window_of(input logic [VW-1:0] v);
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (v > edge_regs[q] && v <= edge_regs[q+1]) return q;
    end
    return -1;
  endfunction

  function automatic fifo_result_t mk_result(input rbfs_pkg::status_t st, input int bk,
                                             input int cnt, input logic [VW-1:0] dat,
                                             input logic lst);
    fifo_result_t r;
    r.status = st;
    r.bucket = bk[rbfs_pkg::SEL_W-1:0];
    r.count  = cnt[CW-1:0];
    r.data   = dat;
    r.last   = lst;
    return r;
  endfunction

  task automatic predict_op(input fifo_op_t op);
    int         q;
    int         n;
    logic [4:0] h;
    case (op.cmd)
      rbfs_pkg::CMD_ENQ: begin
        q = window_of(op.value);
        if (q < 0) begin
          due_results.push_back(mk_result(rbfs_pkg::STAT_RANGE, 0, 0, '0, 1'b1));
        end else if (mirror_fill[q] >= QUEUE_DEPTH) begin
          due_results.push_back(mk_result(rbfs_pkg::STAT_FULL, q, QUEUE_DEPTH, '0, 1'b1));
        end else begin
          mirror_store[q][mirror_head[q] + mirror_fill[q][4:0]] = op.value;
          mirror_fill[q] = mirror_fill[q] + 1'b1;
          due_results.push_back(mk_result(rbfs_pkg::STAT_OK, q, mirror_fill[q], '0, 1'b1));
        end
      end
      rbfs_pkg::CMD_COUNT: begin
        due_results.push_back(mk_result(rbfs_pkg::STAT_OK, op.sel, mirror_fill[op.sel], '0,
                                        1'b1));
      end
      rbfs_pkg::CMD_DRAIN: begin
        n = mirror_fill[op.sel];
        h = mirror_head[op.sel];
        if (n == 0) begin
          due_results.push_back(mk_result(rbfs_pkg::STAT_EMPTY, op.sel, 0, '0, 1'b1));
        end else begin
          for (int i = 0; i < n; i++) begin
            due_results.push_back(mk_result(rbfs_pkg::STAT_DRAINED, op.sel, n - 1 - i,
                                            mirror_store[op.sel][h], i == n - 1));
            h = h + 1'b1;
          end
          mirror_head[op.sel] = h;
          mirror_fill[op.sel] = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (item_taken && !steady_feed && $urandom_range(0, 5) == 0)
        idle_left = $urandom_range(1, 16);
      if (idle_left > 0 && !steady_feed) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        in_cmd       <= cur_op.cmd;
        in_queue_sel <= cur_op.sel;
        in_value     <= cur_op.value;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected", $time);
          $display("%0t: actual status=%0d bucket=%0d count=%0d data=%0d last=%0d",
                   $time, out_status, out_bucket, out_entry_count, out_data_out, out_last);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_status !== want.status || out_bucket !== want.bucket ||
              out_entry_count !== want.count || out_data_out !== want.data ||
              out_last !== want.last) begin
            $display("%0t: mismatch expected status=%0d bucket=%0d count=%0d data=%0d last=%0d",
                     $time, want.status, want.bucket, want.count, want.data, want.last);
            $display("%0t:          actual   status=%0d bucket=%0d count=%0d data=%0d last=%0d",
                     $time, out_status, out_bucket, out_entry_count, out_data_out, out_last);
            fail_count++;
          end
        end
      end
      if (start && !busy) predict_op(cur_op);
      item_taken <= start && !busy;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_op(input rbfs_pkg::cmd_t c, input int s, input logic [VW-1:0] v);
    fifo_op_t op;
    op.cmd   = c;
    op.sel   = s[rbfs_pkg::SEL_W-1:0];
    op.value = v;
    pending_ops.push_back(op);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || start || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_edges(input rbfs_pkg::edge_t e0, input rbfs_pkg::edge_t e1,
                            input rbfs_pkg::edge_t e2, input rbfs_pkg::edge_t e3,
                            input rbfs_pkg::edge_t e4);
    rbfs_pkg::edge_t vals [rbfs_pkg::NUM_REGS];
    vals[0] = e0;
    vals[1] = e1;
    vals[2] = e2;
    vals[3] = e3;
    vals[4] = e4;
    for (int i = 0; i < rbfs_pkg::NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= rbfs_pkg::REG_BOTTOM + i[rbfs_pkg::REG_IDX_W-1:0];
      cfg_data  <= vals[i];
      edge_regs[i] = vals[i];
    end
    // index past the last register must be ignored
    @(negedge clk);
    cfg_index <= rbfs_pkg::REG_TOP + 3'($urandom_range(1, 3));
    cfg_data  <= rbfs_pkg::edge_t'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_bucket(input int q);
    if (edge_regs[q] < edge_regs[q+1]) begin
      for (int i = 0; i < QUEUE_DEPTH + 2; i++)
        queue_op(rbfs_pkg::CMD_ENQ, $urandom_range(0, 3),
                 VW'($urandom_range(edge_regs[q] + 1, edge_regs[q+1])));
      queue_op(rbfs_pkg::CMD_COUNT, q, VW'($urandom));
      queue_op(rbfs_pkg::CMD_DRAIN, q, VW'($urandom));
      queue_op(rbfs_pkg::CMD_DRAIN, q, VW'($urandom));
    end
  endtask

  task automatic random_phase(input int n);
    int       made;
    int       pick;
    int       q;
    fifo_op_t op;
    made = 0;
    while (made < n) begin
      pick     = $urandom_range(0, 99);
      op.sel   = rbfs_pkg::SEL_W'($urandom_range(0, 3));
      op.value = VW'($urandom);
      op.cmd   = rbfs_pkg::CMD_ENQ;
      if (pick < 35) begin
        q = $urandom_range(0, NUM_QUEUES - 1);
        if (edge_regs[q] < edge_regs[q+1])
          op.value = VW'($urandom_range(edge_regs[q] + 1, edge_regs[q+1]));
      end else if (pick < 45) begin
        op.value = edge_regs[$urandom_range(0, rbfs_pkg::NUM_REGS - 1)] +
                   VW'($urandom_range(0, 1));
      end else if (pick < 60) begin
        op.cmd = rbfs_pkg::CMD_ENQ;
      end else if (pick < 75) begin
        op.cmd = rbfs_pkg::CMD_COUNT;
      end else if (pick < 88) begin
        op.cmd = rbfs_pkg::CMD_DRAIN;
      end else if (pick < 94) begin
        op.cmd = rbfs_pkg::CMD_UNUSED;
      end else begin
        op.cmd = rbfs_pkg::cmd_t'($urandom_range(0, 3));
      end
      if (op.cmd != rbfs_pkg::CMD_UNUSED) made++;
      pending_ops.push_back(op);
    end
  endtask

  initial begin
    for (int i = 0; i < rbfs_pkg::NUM_REGS; i++) edge_regs[i] = rbfs_pkg::EDGE_RESET[i];
    for (int q = 0; q < NUM_QUEUES; q++) begin
      mirror_head[q] = '0;
      mirror_fill[q] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // window edges at reset values
    queue_op(rbfs_pkg::CMD_DRAIN, 0, 16'hFFFF);
    queue_op(rbfs_pkg::CMD_ENQ, 3, 16'd0);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd1);
    queue_op(rbfs_pkg::CMD_ENQ, 1, 16'd25);
    queue_op(rbfs_pkg::CMD_ENQ, 2, 16'd26);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd50);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd51);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd75);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd76);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd100);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'd101);
    queue_op(rbfs_pkg::CMD_ENQ, 0, 16'hFFFF);
    queue_op(rbfs_pkg::CMD_UNUSED, 3, 16'hFFFF);
    for (int q = 0; q < NUM_QUEUES; q++) queue_op(rbfs_pkg::CMD_COUNT, q, 16'd0);
    for (int q = 0; q < NUM_QUEUES; q++) queue_op(rbfs_pkg::CMD_DRAIN, q, 16'd0);
    queue_op(rbfs_pkg::CMD_DRAIN, 0, 16'd0);
    queue_op(rbfs_pkg::CMD_COUNT, 3, 16'hAAAA);
    fill_bucket(0);
    fill_bucket(3);
    settle();

    load_edges(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(10);
    settle();
    load_edges(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(10);
    settle();
    load_edges(16'd0, 16'd16383, 16'd32767, 16'd49151, 16'hFFFF);
    fill_bucket($urandom_range(0, 3));
    random_phase(25);
    settle();
    // overlapping and unordered windows
    load_edges(16'd300, 16'd150, 16'd200, 16'd100, 16'd400);
    random_phase(25);
    settle();
    load_edges(rbfs_pkg::edge_t'($urandom), rbfs_pkg::edge_t'($urandom),
               rbfs_pkg::edge_t'($urandom), rbfs_pkg::edge_t'($urandom),
               rbfs_pkg::edge_t'($urandom));
    random_phase(20);
    settle();
    for (int p = 0; p < 2; p++) begin
      edge_regs[0] = rbfs_pkg::edge_t'($urandom_range(0, 1000));
      for (int i = 1; i < rbfs_pkg::NUM_REGS; i++)
        edge_regs[i] = edge_regs[i-1] + rbfs_pkg::edge_t'($urandom_range(0, 8000));
      load_edges(edge_regs[0], edge_regs[1], edge_regs[2], edge_regs[3], edge_regs[4]);
      random_phase(20);
      settle();
    end

    steady_feed = 1'b1;
    load_edges(rbfs_pkg::EDGE_RESET[0], rbfs_pkg::EDGE_RESET[1], rbfs_pkg::EDGE_RESET[2],
               rbfs_pkg::EDGE_RESET[3], rbfs_pkg::EDGE_RESET[4]);
    random_phase(25);
    settle();

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
